/* rtl/gti_pkg.sv */
package gti_pkg;

  // grid store geometry; DEPTH is a power of two so read indices wrap by truncation
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NY     = 16;
  localparam int NZ     = 16;

  // field and datapath widths
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 3;
  localparam int U_W       = 21;   // local coordinate, clamped to +/-8.0 in Q16.16
  localparam int A_W       = 33;
  localparam int B_W       = 36;
  localparam int H_W       = 43;   // Horner partial sums
  localparam int M_W       = U_W + H_W;
  localparam int R_W       = 48;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(16);
  localparam logic [31:0]       INV_RST  = 32'h0001_0000;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_LINE  = 2'd1,
    KIND_GRID  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X   = 3'd0,
    CFG_ORIGIN_X = 3'd1,
    CFG_ORIGIN_Y = 3'd2,
    CFG_ORIGIN_Z = 3'd3,
    CFG_INV_X    = 3'd4,
    CFG_INV_Y    = 3'd5,
    CFG_INV_Z    = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    LVL_Z = 2'd0,
    LVL_Y = 2'd1,
    LVL_X = 2'd2
  } level_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       wr;
    logic       ax_mul;
    logic       ax_sat;
    logic       ax_win;
    axis_t      axis;
    logic       rd_issue;
    logic       rd_capture;
    logic [1:0] rd_k;
    logic [1:0] slot;
    logic [1:0] i;
    logic [1:0] j;
    level_t     level;
    logic       cu_abc;
    logic       cu_mul;
    logic       cu_mul_c;
    logic       cu_h1;
    logic       cu_h2;
    logic       cu_r;
  } gti_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic grid_mode;
  } gti_stat_t;

endpackage

/* rtl/gti_ctrl.sv */
module gti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_kind,
  input  gti_pkg::gti_stat_t stat,
  output logic              busy,
  output logic              out_valid,
  output gti_pkg::gti_cmd_t cmd
);
  import gti_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_AX_MUL = 12'b0000_0000_0010,
    ST_AX_SAT = 12'b0000_0000_0100,
    ST_AX_WIN = 12'b0000_0000_1000,
    ST_RD     = 12'b0000_0001_0000,
    ST_C_ABC  = 12'b0000_0010_0000,
    ST_C_M1   = 12'b0000_0100_0000,
    ST_C_H1   = 12'b0000_1000_0000,
    ST_C_M2   = 12'b0001_0000_0000,
    ST_C_H2   = 12'b0010_0000_0000,
    ST_C_M3   = 12'b0100_0000_0000,
    ST_C_R    = 12'b1000_0000_0000
  } state_t;

  state_t     state_r, state_nxt;
  axis_t      axis_r, axis_nxt;
  level_t     level_r, level_nxt;
  logic [2:0] k_r, k_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] j_r, j_nxt;
  logic       valid_r, valid_nxt;
  logic       take;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign take      = start && !busy;

  // decode commands from the current state and from an accepted transfer
  always_comb begin
    cmd            = '0;
    cmd.load       = take && (in_kind == KIND_LINE || in_kind == KIND_GRID);
    cmd.wr         = take && (in_kind == KIND_WRITE);
    cmd.ax_mul     = (state_r == ST_AX_MUL);
    cmd.ax_sat     = (state_r == ST_AX_SAT);
    cmd.ax_win     = (state_r == ST_AX_WIN);
    cmd.axis       = axis_r;
    cmd.rd_issue   = (state_r == ST_RD) && !k_r[2];
    cmd.rd_capture = (state_r == ST_RD) && (k_r != 3'd0);
    cmd.rd_k       = k_r[1:0];
    cmd.slot       = k_r[1:0] - 2'd1;
    cmd.i          = i_r;
    cmd.j          = j_r;
    cmd.level      = level_r;
    cmd.cu_abc     = (state_r == ST_C_ABC);
    cmd.cu_mul     = (state_r == ST_C_M1) || (state_r == ST_C_M2) || (state_r == ST_C_M3);
    cmd.cu_mul_c   = (state_r == ST_C_M1);
    cmd.cu_h1      = (state_r == ST_C_H1);
    cmd.cu_h2      = (state_r == ST_C_H2);
    cmd.cu_r       = (state_r == ST_C_R);
  end

  // sequence: axis setup, then read four samples and run one cubic, nested z/y/x
  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    level_nxt = level_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_AX_MUL;
          axis_nxt  = AXIS_X;
        end
      end
      ST_AX_MUL: state_nxt = ST_AX_SAT;
      ST_AX_SAT: state_nxt = ST_AX_WIN;
      ST_AX_WIN: begin
        if (!stat.grid_mode || axis_r == AXIS_Z) begin
          state_nxt = ST_RD;
          k_nxt     = 3'd0;
          i_nxt     = 2'd0;
          j_nxt     = 2'd0;
          level_nxt = stat.grid_mode ? LVL_Z : LVL_X;
        end else begin
          state_nxt = ST_AX_MUL;
          axis_nxt  = (axis_r == AXIS_X) ? AXIS_Y : AXIS_Z;
        end
      end
      ST_RD: begin
        k_nxt = k_r + 3'd1;
        if (k_r[2]) begin
          state_nxt = ST_C_ABC;
        end
      end
      ST_C_ABC: state_nxt = ST_C_M1;
      ST_C_M1:  state_nxt = ST_C_H1;
      ST_C_H1:  state_nxt = ST_C_M2;
      ST_C_M2:  state_nxt = ST_C_H2;
      ST_C_H2:  state_nxt = ST_C_M3;
      ST_C_M3:  state_nxt = ST_C_R;
      ST_C_R: begin
        unique case (level_r)
          LVL_Z: begin
            if (j_r == 2'd3) begin
              level_nxt = LVL_Y;
              state_nxt = ST_C_ABC;
            end else begin
              j_nxt     = j_r + 2'd1;
              k_nxt     = 3'd0;
              state_nxt = ST_RD;
            end
          end
          LVL_Y: begin
            if (i_r == 2'd3) begin
              level_nxt = LVL_X;
              state_nxt = ST_C_ABC;
            end else begin
              i_nxt     = i_r + 2'd1;
              j_nxt     = 2'd0;
              k_nxt     = 3'd0;
              level_nxt = LVL_Z;
              state_nxt = ST_RD;
            end
          end
          LVL_X: begin
            valid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AXIS_X;
      level_r <= LVL_X;
      k_r     <= 3'd0;
      i_r     <= 2'd0;
      j_r     <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      level_r <= level_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

/* rtl/gti_dp.sv */
module gti_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gti_pkg::gti_cmd_t               cmd,
  input  logic                            cfg_we,
  input  logic [gti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic [1:0]                      in_kind,
  input  logic [11:0]                     in_address,
  input  logic signed [31:0]              in_sample,
  input  logic signed [31:0]              in_pos_x,
  input  logic signed [31:0]              in_pos_y,
  input  logic signed [31:0]              in_pos_z,
  output gti_pkg::gti_stat_t              stat,
  output logic signed [31:0]              out_value,
  output logic                            out_saturated
);
  import gti_pkg::*;

  // configuration
  logic [SIZE_W-1:0]  size_x_r;
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic [31:0]        inv_x_r, inv_y_r, inv_z_r;

  // query state
  logic               grid_mode_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic               flag_r;
  logic signed [31:0] result_r;

  // axis setup
  logic               neg_r;
  logic [63:0]        prod_r;
  logic signed [31:0] t_r;
  logic [SIZE_W-1:0]  ox_r, oy_r, oz_r;
  logic signed [U_W-1:0] ux_r, uy_r, uz_r;

  // samples and partial results
  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_r;
  logic signed [31:0] pz_r [4];
  logic signed [31:0] py_r [4];
  logic signed [31:0] px_r [4];

  // cubic unit
  logic signed [A_W-1:0] a_r;
  logic signed [B_W-1:0] b_r, c_r;
  logic signed [H_W-1:0] h_r;
  logic signed [M_W-1:0] m_r;

  assign stat.grid_mode = grid_mode_r;
  assign out_value      = result_r;
  assign out_saturated  = flag_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SIZE_RST;
      org_x_r  <= '0;
      org_y_r  <= '0;
      org_z_r  <= '0;
      inv_x_r  <= INV_RST;
      inv_y_r  <= INV_RST;
      inv_z_r  <= INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIZE_X:   size_x_r <= cfg_wdata[SIZE_W-1:0];
        CFG_ORIGIN_X: org_x_r  <= $signed(cfg_wdata);
        CFG_ORIGIN_Y: org_y_r  <= $signed(cfg_wdata);
        CFG_ORIGIN_Z: org_z_r  <= $signed(cfg_wdata);
        CFG_INV_X:    inv_x_r  <= cfg_wdata;
        CFG_INV_Y:    inv_y_r  <= cfg_wdata;
        CFG_INV_Z:    inv_z_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // select the axis under setup
  logic signed [31:0] ax_pos, ax_org;
  logic [31:0]        ax_inv;
  logic [SIZE_W-1:0]  ax_n, nx;

  assign nx = (size_x_r < SIZE_MIN) ? SIZE_MIN : size_x_r;

  always_comb begin
    unique case (cmd.axis)
      AXIS_Y: begin
        ax_pos = pos_y_r;
        ax_org = org_y_r;
        ax_inv = inv_y_r;
        ax_n   = SIZE_W'(NY);
      end
      AXIS_Z: begin
        ax_pos = pos_z_r;
        ax_org = org_z_r;
        ax_inv = inv_z_r;
        ax_n   = SIZE_W'(NZ);
      end
      default: begin
        ax_pos = pos_x_r;
        ax_org = org_x_r;
        ax_inv = inv_x_r;
        ax_n   = nx;
      end
    endcase
  end

  // scale: |pos - origin| times inverse step
  logic signed [32:0] d;
  logic [32:0]        d_neg;
  logic [31:0]        mag;

  assign d     = 33'(ax_pos) - 33'(ax_org);
  assign d_neg = 33'(0) - d;
  assign mag   = d[32] ? d_neg[31:0] : d[31:0];

  // saturate the Q16.16 grid coordinate
  logic [47:0]        q;
  logic signed [31:0] t_nxt;
  logic               t_sat;

  assign q = prod_r[63:16];

  always_comb begin
    t_sat = 1'b0;
    if (neg_r) begin
      if (q > 48'h0000_8000_0000) begin
        t_sat = 1'b1;
        t_nxt = 32'sh8000_0000;
      end else begin
        t_nxt = $signed(32'(0) - q[31:0]);
      end
    end else begin
      if (q > 48'h0000_7FFF_FFFF) begin
        t_sat = 1'b1;
        t_nxt = 32'sh7FFF_FFFF;
      end else begin
        t_nxt = $signed(q[31:0]);
      end
    end
  end

  // window start and local coordinate
  logic [32:0]        t_mag;
  logic signed [17:0] ind, n_ext;
  logic [SIZE_W-1:0]  off;
  logic signed [33:0] u_wide;
  logic signed [U_W-1:0] u_nxt;
  logic               u_sat;

  assign t_mag = 33'(0) - 33'(t_r);
  assign ind   = t_r[31] ? (18'sd0 - $signed({1'b0, t_mag[32:16]}))
                         : $signed({2'b00, t_r[31:16]});
  assign n_ext = $signed({5'b0, ax_n});

  always_comb begin
    off = '0;
    if (ind > 18'sd1) begin
      if (ind > n_ext - 18'sd3) begin
        off = ax_n - SIZE_W'(4);
      end else begin
        off = ind[SIZE_W-1:0] - SIZE_W'(1);
      end
    end
  end

  assign u_wide = 34'(t_r) - $signed({5'b0, off, 16'b0}) - 34'sd65536;

  always_comb begin
    u_sat = 1'b0;
    u_nxt = u_wide[U_W-1:0];
    if (u_wide > 34'sd524288) begin
      u_sat = 1'b1;
      u_nxt = U_W'(524288);
    end else if (u_wide < -34'sd524288) begin
      u_sat = 1'b1;
      u_nxt = -U_W'(524288);
    end
  end

  // grid read address; flat index wraps to the store depth
  logic [31:0]       flat;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    if (grid_mode_r) begin
      flat = (32'(ox_r) + 32'(cmd.i)) * 32'(NY * NZ)
           + (32'(oy_r) + 32'(cmd.j)) * 32'(NZ)
           + 32'(oz_r) + 32'(cmd.rd_k);
    end else begin
      flat = 32'(ox_r) + 32'(cmd.rd_k);
    end
  end

  assign rd_addr = flat[ADDR_W-1:0];

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(in_address) < 32'(DEPTH))) begin
      mem[in_address[ADDR_W-1:0]] <= in_sample;
    end
    if (cmd.rd_issue) begin
      rd_r <= mem[rd_addr];
    end
  end

  // cubic operands for the current level
  logic signed [31:0]    p0, p1, p2, p3;
  logic signed [U_W-1:0] u_sel;

  always_comb begin
    unique case (cmd.level)
      LVL_Z: begin
        p0 = pz_r[0]; p1 = pz_r[1]; p2 = pz_r[2]; p3 = pz_r[3];
        u_sel = uz_r;
      end
      LVL_Y: begin
        p0 = py_r[0]; p1 = py_r[1]; p2 = py_r[2]; p3 = py_r[3];
        u_sel = uy_r;
      end
      default: begin
        p0 = px_r[0]; p1 = px_r[1]; p2 = px_r[2]; p3 = px_r[3];
        u_sel = ux_r;
      end
    endcase
  end

  // Catmull-Rom coefficients
  logic signed [B_W-1:0] e0, e1, e2, e3, e12;
  logic signed [A_W-1:0] a_nxt;
  logic signed [B_W-1:0] b_nxt, c_nxt;

  assign e0    = B_W'(p0);
  assign e1    = B_W'(p1);
  assign e2    = B_W'(p2);
  assign e3    = B_W'(p3);
  assign e12   = e1 - e2;
  assign a_nxt = A_W'(p2) - A_W'(p0);
  assign b_nxt = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign c_nxt = (e12 <<< 1) + e12 + e3 - e0;

  // shared multiplier, Horner steps and final saturation
  logic signed [H_W-1:0] mul_b;
  logic signed [M_W-1:0] m_nxt, m_sh16, m_sh17;
  logic signed [R_W-1:0] r_wide;
  logic signed [31:0]    r_sat;
  logic                  r_flag;

  assign mul_b  = cmd.cu_mul_c ? H_W'(c_r) : h_r;
  assign m_nxt  = u_sel * mul_b;
  assign m_sh16 = m_r >>> 16;
  assign m_sh17 = m_r >>> 17;
  assign r_wide = R_W'(p1) + m_sh17[R_W-1:0];

  always_comb begin
    r_flag = 1'b0;
    r_sat  = r_wide[31:0];
    if (r_wide > R_W'(32'sh7FFF_FFFF)) begin
      r_flag = 1'b1;
      r_sat  = 32'sh7FFF_FFFF;
    end else if (r_wide < R_W'(32'sh8000_0000)) begin
      r_flag = 1'b1;
      r_sat  = 32'sh8000_0000;
    end
  end

  // query, axis and cubic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grid_mode_r <= (in_kind == KIND_GRID);
      pos_x_r     <= in_pos_x;
      pos_y_r     <= in_pos_y;
      pos_z_r     <= in_pos_z;
    end
    if (cmd.ax_mul) begin
      neg_r  <= d[32];
      prod_r <= mag * ax_inv;
    end
    if (cmd.ax_sat) begin
      t_r <= t_nxt;
    end
    if (cmd.ax_win) begin
      unique case (cmd.axis)
        AXIS_Y: begin
          oy_r <= off;
          uy_r <= u_nxt;
        end
        AXIS_Z: begin
          oz_r <= off;
          uz_r <= u_nxt;
        end
        default: begin
          ox_r <= off;
          ux_r <= u_nxt;
        end
      endcase
    end
    if (cmd.rd_capture) begin
      if (grid_mode_r) begin
        pz_r[cmd.slot] <= $signed(rd_r);
      end else begin
        px_r[cmd.slot] <= $signed(rd_r);
      end
    end
    if (cmd.cu_abc) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
    if (cmd.cu_mul) begin
      m_r <= m_nxt;
    end
    if (cmd.cu_h1) begin
      h_r <= H_W'(b_r) + m_sh16[H_W-1:0];
    end
    if (cmd.cu_h2) begin
      h_r <= H_W'(a_r) + m_sh16[H_W-1:0];
    end
    if (cmd.cu_r) begin
      unique case (cmd.level)
        LVL_Z:   py_r[cmd.j] <= r_sat;
        LVL_Y:   px_r[cmd.i] <= r_sat;
        default: result_r    <= r_sat;
      endcase
    end
  end

  // clipping flag: clear per query, collect from every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (cmd.load) begin
      flag_r <= 1'b0;
    end else if ((cmd.ax_sat && t_sat) || (cmd.ax_win && u_sat) || (cmd.cu_r && r_flag)) begin
      flag_r <= 1'b1;
    end
  end

endmodule

/* rtl/grid_tricubic_interpolator_core.sv */
// Channel   Ports                                        Transfer
// input     start, busy, in_kind/address/sample/pos_*    start high while busy low
// result    out_valid, out_value, out_saturated          out_valid high, one cycle
// config    cfg_we, cfg_index, cfg_wdata                 cfg_we high
//
// A sample write leaves busy low. A 1D query runs axis setup on x, then 4 reads and
// one cubic; a 3D query runs axis setup on x, y and z, then 16 groups of 4 reads on
// the single store port plus one cubic each, and 5 more cubics. Every cubic takes 7
// steps through one shared multiplier. Reset (rst_n low, synchronous) returns the
// controller to idle and the configuration and clipping flag registers to their
// reset values; the sample store is not cleared. Results cannot be stalled.
module grid_tricubic_interpolator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [11:0]                   in_address,
  input  logic signed [31:0]            in_sample,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  output logic                          out_valid,
  output logic signed [31:0]            out_value,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [gti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import gti_pkg::*;

  gti_cmd_t  cmd;
  gti_stat_t stat;

  gti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_kind   (in_kind),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  gti_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_kind       (in_kind),
    .in_address    (in_address),
    .in_sample     (in_sample),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .stat          (stat),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

endmodule

/* sim/grid_tricubic_interpolator_core_test.sv */
module grid_tricubic_interpolator_core_test;
  import gti_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } interp_result_t;

  // Predicts interpolated values and checks them in order of arrival
  class interp_scoreboard;
    bit [31:0]      samples [DEPTH];
    int unsigned    size_x;
    longint         org [3];
    longint         inv [3];
    interp_result_t awaited [$];
    int             errors;

    function void reset_regs();
      size_x = 16;
      foreach (org[a]) begin
        org[a] = 0;
        inv[a] = 65536;
      end
    endfunction

    function void set_reg(cfg_idx_t idx, bit [31:0] v);
      case (idx)
        CFG_SIZE_X:   size_x = v & 32'h1FFF;
        CFG_ORIGIN_X: org[0] = longint'($signed(v));
        CFG_ORIGIN_Y: org[1] = longint'($signed(v));
        CFG_ORIGIN_Z: org[2] = longint'($signed(v));
        CFG_INV_X:    inv[0] = longint'(v);
        CFG_INV_Y:    inv[1] = longint'(v);
        CFG_INV_Z:    inv[2] = longint'(v);
        default: ;
      endcase
    endfunction

    function longint sample_at(longint idx);
      return longint'($signed(samples[idx % DEPTH]));
    endfunction

    // Scale one coordinate, pick its window start, return the local coordinate
    function longint local_coord(longint pos, int a, longint n, output longint off,
                                 inout bit flag);
      longint d, t, ind, u;
      bit [63:0] mag, q;
      d = pos - org[a];
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q = (mag * 64'(inv[a])) >> 16;
      if (d < 0) begin
        if (q > 64'h8000_0000) begin
          flag = 1;
          q = 64'h8000_0000;
        end
        t = -longint'(q);
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          flag = 1;
          q = 64'h7FFF_FFFF;
        end
        t = longint'(q);
      end
      ind = (t >= 0) ? (t >>> 16) : -((-t) >>> 16);
      off = 0;
      if (ind > 1) begin
        off = ind - 1;
        if (ind > n - 3) off = n - 4;
      end
      u = t - off * 65536 - 65536;
      if (u > 8 * 65536) begin
        flag = 1;
        u = 8 * 65536;
      end
      if (u < -8 * 65536) begin
        flag = 1;
        u = -8 * 65536;
      end
      return u;
    endfunction

    function longint catmull(longint p0, longint p1, longint p2, longint p3, longint u,
                             inout bit flag);
      longint a, b, c, h, r;
      a = p2 - p0;
      b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      c = 3 * (p1 - p2) + p3 - p0;
      h = b + ((u * c) >>> 16);
      h = a + ((u * h) >>> 16);
      r = p1 + ((u * h) >>> 17);
      if (r > 64'sd2147483647) begin
        flag = 1;
        r = 64'sd2147483647;
      end
      if (r < -64'sd2147483648) begin
        flag = 1;
        r = -64'sd2147483648;
      end
      return r;
    endfunction

    // Note one accepted transfer and queue its result, if any
    function void note(kind_t kind, bit [11:0] addr, bit [31:0] smp,
                       bit [31:0] px, bit [31:0] py, bit [31:0] pz);
      bit             flag;
      longint         nx, ox, oy, oz, ux, uy, uz, r;
      longint         pxv [4];
      longint         pyv [4];
      longint         pzv [4];
      interp_result_t e;
      flag = 0;
      if (kind == KIND_WRITE) begin
        samples[addr] = smp;
        return;
      end
      if (kind == KIND_NONE) return;
      nx = (size_x < 4) ? 4 : size_x;
      ux = local_coord(longint'($signed(px)), 0, nx, ox, flag);
      if (kind == KIND_LINE) begin
        for (int i = 0; i < 4; i++) pxv[i] = sample_at(ox + i);
      end else begin
        uy = local_coord(longint'($signed(py)), 1, NY, oy, flag);
        uz = local_coord(longint'($signed(pz)), 2, NZ, oz, flag);
        for (int i = 0; i < 4; i++) begin
          for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++)
              pzv[k] = sample_at((ox + i) * NY * NZ + (oy + j) * NZ + oz + k);
            pyv[j] = catmull(pzv[0], pzv[1], pzv[2], pzv[3], uz, flag);
          end
          pxv[i] = catmull(pyv[0], pyv[1], pyv[2], pyv[3], uy, flag);
        end
      end
      r = catmull(pxv[0], pxv[1], pxv[2], pxv[3], ux, flag);
      e.value = 32'(r);
      e.sat = flag;
      awaited.push_back(e);
    endfunction

    function void check(logic signed [31:0] v, logic s);
      interp_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result value=%0d sat=%0b", v, s);
        return;
      end
      e = awaited.pop_front();
      if (e.value !== v || e.sat !== s) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value=%0d sat=%0b, got value=%0d sat=%0b",
                   e.value, e.sat, v, s);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy;
  logic [1:0] in_kind;
  logic [11:0] in_address;
  logic signed [31:0] in_sample, in_pos_x, in_pos_y, in_pos_z;
  logic out_valid, out_saturated;
  logic signed [31:0] out_value;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  interp_scoreboard sb;
  bit               idling_on;
  int unsigned      cycles;

  grid_tricubic_interpolator_core dut (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Cut the run short if the block hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_tricubic_interpolator_core verification failed");
      $finish;
    end
  end

  // Check every result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_value, out_saturated);
  end

  // Present one item and hold it until the transfer; caller is at a falling edge
  task automatic send_item(kind_t kind, bit [11:0] addr, bit [31:0] smp,
                           bit [31:0] px, bit [31:0] py, bit [31:0] pz);
    in_kind = kind;
    in_address = addr;
    in_sample = smp;
    in_pos_x = px;
    in_pos_y = py;
    in_pos_z = pz;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note(kind, addr, smp, px, py, pz);
    @(negedge clk);
    start = 1'b0;
  endtask

  // Drop start for a random burst, with junk on the fields
  task automatic sender_gap();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_kind = 2'($urandom);
      in_address = 12'($urandom);
      in_sample = $urandom;
      in_pos_x = $urandom;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // Hold off until the block is idle and every result has arrived
  task automatic drain();
    while (sb.awaited.size() != 0) @(negedge clk);
    repeat (260) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [31:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_wdata = $urandom;
    sb.set_reg(idx, v);
  endtask

  // Coordinate that lands near the grid on one axis, sometimes anywhere
  function automatic bit [31:0] near_pos(int a, longint n);
    longint t, p;
    if ($urandom_range(0, 9) < 2) return $urandom;
    t = longint'($urandom_range(0, 32'(n + 6) * 65536)) - 3 * 65536;
    p = sb.org[a] + (t * 65536) / sb.inv[a];
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
    return 32'(p);
  endfunction

  function automatic bit [31:0] rand_sample();
    return 32'($signed($urandom) >>> $urandom_range(0, 10));
  endfunction

  task automatic random_item();
    int     pick;
    longint nx;
    pick = $urandom_range(0, 99);
    nx = (sb.size_x < 4) ? 4 : sb.size_x;
    if (pick < 15)
      send_item(KIND_WRITE, 12'($urandom), rand_sample(), $urandom, $urandom, $urandom);
    else if (pick < 55)
      send_item(KIND_LINE, 12'($urandom), $urandom, near_pos(0, nx), $urandom, $urandom);
    else if (pick < 95)
      send_item(KIND_GRID, 12'($urandom), $urandom, near_pos(0, nx), near_pos(1, NY),
                near_pos(2, NZ));
    else
      send_item(KIND_NONE, 12'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic set_all(bit [31:0] sz, bit [31:0] ox, bit [31:0] oy, bit [31:0] oz,
                         bit [31:0] ix, bit [31:0] iy, bit [31:0] iz);
    write_reg(CFG_SIZE_X, sz);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_X, ix);
    write_reg(CFG_INV_Y, iy);
    write_reg(CFG_INV_Z, iz);
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    idling_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_WRITE;
    in_address = '0;
    in_sample = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_SIZE_X;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole store so no query reads an unwritten entry
    for (int a = 0; a < DEPTH; a++)
      send_item(KIND_WRITE, 12'(a), rand_sample(), $urandom, $urandom, $urandom);

    // Directed: field extremes, every kind, far coordinates
    send_item(KIND_WRITE, 12'd0, 32'h8000_0000, 0, 0, 0);
    send_item(KIND_WRITE, 12'd4095, 32'h7FFF_FFFF, 0, 0, 0);
    send_item(KIND_LINE, 0, 0, 32'h0000_0000, 0, 0);
    send_item(KIND_LINE, 0, 0, 32'h0001_8000, 0, 0);
    send_item(KIND_LINE, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_item(KIND_LINE, 0, 0, 32'h8000_0000, 0, 0);
    send_item(KIND_LINE, 0, 0, 32'h000F_0000, 0, 0);
    send_item(KIND_GRID, 0, 0, 32'h0002_4000, 32'h0005_8000, 32'h000A_1000);
    send_item(KIND_GRID, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(KIND_GRID, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(KIND_GRID, 0, 0, 32'h0000_0000, 32'h000F_FFFF, 32'hFFF0_0000);
    send_item(KIND_GRID, 0, 0, 32'h0010_0000, 32'h0000_0000, 32'h0011_0000);
    send_item(KIND_NONE, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_WRITE, 12'd0, rand_sample(), 0, 0, 0);
    send_item(KIND_WRITE, 12'd4095, rand_sample(), 0, 0, 0);
    for (int n = 0; n < 150; n++) begin
      sender_gap();
      random_item();
    end

    // Walk through register settings, extremes first
    for (int ph = 1; ph <= 7; ph++) begin
      drain();
      case (ph)
        1: set_all(4, 0, 0, 0, 65536, 65536, 65536);
        2: set_all(4096, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 65536);
        3: set_all(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000, 1, 32'hFFFF_FFFF,
                   32'h0000_8000);
        default:
          set_all($urandom_range(0, 3) == 0 ? $urandom_range(4, 4096) : $urandom_range(4, 24),
                  32'($signed($urandom) >>> $urandom_range(4, 20)),
                  32'($signed($urandom) >>> $urandom_range(4, 20)),
                  32'($signed($urandom) >>> $urandom_range(4, 20)),
                  $urandom_range(1 << 13, 1 << 19), $urandom_range(1 << 13, 1 << 19),
                  $urandom_range(1 << 13, 1 << 19));
      endcase
      for (int n = 0; n < 230; n++) begin
        if (ph == 7 && n >= 130) idling_on = 1'b0;
        if (ph == 5 && n == 100) begin
          // Let the block empty out completely once mid-phase
          while (sb.awaited.size() != 0) @(negedge clk);
        end
        sender_gap();
        random_item();
      end
    end

    drain();
    if (sb.errors == 0)
      $display("grid_tricubic_interpolator_core verification clean");
    else
      $display("grid_tricubic_interpolator_core verification failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/gti_pkg.sv
rtl/gti_ctrl.sv
rtl/gti_dp.sv
rtl/grid_tricubic_interpolator_core.sv
sim/grid_tricubic_interpolator_core_test.sv
